// File: rtl/cfa_pkg.sv
// Shared types, constants and the clamp function of the complex fixed-point ALU.
package cfa_pkg;

  localparam int PW     = 16;       // width of one complex part
  localparam int FB     = 8;        // fraction bits
  localparam int CW     = 3;        // command width
  localparam int PROD_W = 2 * PW;   // one signed product
  localparam int WIDE_W = PROD_W + 1;
  localparam int MAG_W  = PROD_W;   // magnitude of a sum of two products
  localparam int REM_W  = MAG_W + FB;
  localparam int QW     = PW;       // quotient bits left after the overflow check
  localparam int RW     = PW;       // root bits
  localparam int ITERS  = 16;       // one quotient bit and one root bit per stage

  typedef enum logic [CW-1:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_CONJ = 3'd4,
    CMD_MAG  = 3'd5
  } cfa_cmd_e;

  typedef struct packed {
    logic [CW-1:0]    cmd;
    logic [PW-1:0]    z_re;
    logic [PW-1:0]    z_im;
    logic             sat;
    logic             dz;
    logic             re_neg;
    logic [MAG_W-1:0] re_mag;
    logic             im_neg;
    logic [MAG_W-1:0] im_mag;
    logic [MAG_W-1:0] den;
    logic [MAG_W-1:0] sq;
  } cfa_work_t;

  typedef struct packed {
    logic [CW-1:0]    cmd;
    logic [PW-1:0]    z_re;
    logic [PW-1:0]    z_im;
    logic             sat;
    logic             dz;
    logic             re_neg;
    logic             im_neg;
    logic             re_ovf;
    logic             im_ovf;
    logic [MAG_W-1:0] den;
    logic [REM_W-1:0] re_rem;
    logic [REM_W-1:0] im_rem;
    logic [QW-1:0]    re_q;
    logic [QW-1:0]    im_q;
    logic [MAG_W-1:0] sq_rem;
    logic [RW-1:0]    root;
  } cfa_iter_t;

  typedef struct packed {
    logic [PW-1:0] val;
    logic          sat;
  } cfa_clamp_t;

  function automatic cfa_clamp_t clamp_part(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    cfa_clamp_t r;
    hi = (WIDE_W'(1) <<< (PW - 1)) - WIDE_W'(1);
    lo = -(WIDE_W'(1) <<< (PW - 1));
    if (v > hi) begin
      r.val = hi[PW-1:0];
      r.sat = 1'b1;
    end else if (v < lo) begin
      r.val = lo[PW-1:0];
      r.sat = 1'b1;
    end else begin
      r.val = v[PW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: rtl/cfa_prep.sv
// Front stages: operand products, then sums, simple results and divide setup.
module cfa_prep import cfa_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [CW-1:0] cmd_i,
  input  logic [PW-1:0] a_re_i,
  input  logic [PW-1:0] a_im_i,
  input  logic [PW-1:0] b_re_i,
  input  logic [PW-1:0] b_im_i,
  output logic          valid_o,
  input  logic          ready_i,
  output cfa_work_t     work_o
);

  logic v1_q, v2_q, rdy1, rdy2;
  logic [CW-1:0] cmd_q;
  logic signed [PW:0] sum_re_q, sum_im_q, sum_re_d, sum_im_d;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bb_q, p_cc_q, p_aa_q, p_dd_q;
  logic signed [PW-1:0] ar, ai, br, bi;
  cfa_work_t work_d, work_q;

  assign ar = $signed(a_re_i);
  assign ai = $signed(a_im_i);
  assign br = $signed(b_re_i);
  assign bi = $signed(b_im_i);

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v2_q;
  assign work_o  = work_q;

  always_comb begin
    sum_re_d = '0;
    sum_im_d = '0;
    case (cmd_i)
      CMD_ADD: begin
        sum_re_d = (PW+1)'(ar) + (PW+1)'(br);
        sum_im_d = (PW+1)'(ai) + (PW+1)'(bi);
      end
      CMD_SUB: begin
        sum_re_d = (PW+1)'(ar) - (PW+1)'(br);
        sum_im_d = (PW+1)'(ai) - (PW+1)'(bi);
      end
      CMD_CONJ: begin
        sum_re_d = (PW+1)'(ar);
        sum_im_d = -(PW+1)'(ai);
      end
      default: begin
        sum_re_d = '0;
        sum_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy1) begin
      cmd_q    <= cmd_i;
      sum_re_q <= sum_re_d;
      sum_im_q <= sum_im_d;
      p_rr_q   <= ar * br;
      p_ii_q   <= ai * bi;
      p_ri_q   <= ar * bi;
      p_ir_q   <= ai * br;
      p_bb_q   <= br * br;
      p_cc_q   <= bi * bi;
      p_aa_q   <= ar * ar;
      p_dd_q   <= ai * ai;
    end
  end

  logic signed [WIDE_W-1:0] mul_re, mul_im, n_re, n_im;
  cfa_clamp_t c_re, c_im;

  always_comb begin
    work_d = '0;
    work_d.cmd = cmd_q;
    mul_re = (WIDE_W'(p_rr_q) - WIDE_W'(p_ii_q)) >>> FB;
    mul_im = (WIDE_W'(p_ri_q) + WIDE_W'(p_ir_q)) >>> FB;
    n_re   = WIDE_W'(p_rr_q) + WIDE_W'(p_ii_q);
    n_im   = WIDE_W'(p_ir_q) - WIDE_W'(p_ri_q);
    c_re   = clamp_part(WIDE_W'(sum_re_q));
    c_im   = clamp_part(WIDE_W'(sum_im_q));
    if (cmd_q == CMD_MUL) begin
      c_re = clamp_part(mul_re);
      c_im = clamp_part(mul_im);
    end
    work_d.z_re   = c_re.val;
    work_d.z_im   = c_im.val;
    work_d.sat    = c_re.sat | c_im.sat;
    work_d.re_neg = n_re[WIDE_W-1];
    work_d.re_mag = n_re[WIDE_W-1] ? MAG_W'(-n_re) : MAG_W'(n_re);
    work_d.im_neg = n_im[WIDE_W-1];
    work_d.im_mag = n_im[WIDE_W-1] ? MAG_W'(-n_im) : MAG_W'(n_im);
    work_d.den    = MAG_W'(p_bb_q) + MAG_W'(p_cc_q);
    work_d.dz     = (work_d.den == '0);
    work_d.sq     = MAG_W'(p_aa_q) + MAG_W'(p_dd_q);
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) work_q <= work_d;
  end

endmodule

// File: rtl/cfa_iter.sv
// Digit pipeline: two restoring dividers and a square root, one bit per stage.
module cfa_iter import cfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  cfa_work_t work_i,
  output logic      valid_o,
  input  logic      ready_i,
  output cfa_iter_t iter_o
);

  logic      [ITERS:0] v_q;
  logic      [ITERS+1:0] rdy;
  cfa_iter_t st_q [ITERS+1];
  cfa_iter_t st_d [ITERS+1];

  assign rdy[ITERS+1] = ready_i;
  assign ready_o      = rdy[0];
  assign valid_o      = v_q[ITERS];
  assign iter_o       = st_q[ITERS];

  for (genvar k = 0; k <= ITERS; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  // Overflow check: quotient of 2^QW or more saturates either way.
  always_comb begin
    st_d[0]        = '0;
    st_d[0].cmd    = work_i.cmd;
    st_d[0].z_re   = work_i.z_re;
    st_d[0].z_im   = work_i.z_im;
    st_d[0].sat    = work_i.sat;
    st_d[0].dz     = work_i.dz;
    st_d[0].re_neg = work_i.re_neg;
    st_d[0].im_neg = work_i.im_neg;
    st_d[0].den    = work_i.den;
    st_d[0].re_ovf = {{FB{1'b0}}, work_i.re_mag} >= {work_i.den, {FB{1'b0}}};
    st_d[0].im_ovf = {{FB{1'b0}}, work_i.im_mag} >= {work_i.den, {FB{1'b0}}};
    st_d[0].re_rem = {work_i.re_mag, {FB{1'b0}}};
    st_d[0].im_rem = {work_i.im_mag, {FB{1'b0}}};
    st_d[0].sq_rem = work_i.sq;
  end

  for (genvar k = 1; k <= ITERS; k++) begin : g_step
    localparam int B  = ITERS - k;
    localparam int DW = REM_W + QW;
    localparam int SW = MAG_W + 2;
    logic [DW-1:0] dsh;
    logic [SW-1:0] trial;
    always_comb begin
      st_d[k] = st_q[k-1];
      dsh     = DW'(st_q[k-1].den) << B;
      trial   = (SW'(st_q[k-1].root) << (B + 1)) + (SW'(1) << (2 * B));
      if (DW'(st_q[k-1].re_rem) >= dsh) begin
        st_d[k].re_rem    = st_q[k-1].re_rem - REM_W'(dsh);
        st_d[k].re_q[B]   = 1'b1;
      end
      if (DW'(st_q[k-1].im_rem) >= dsh) begin
        st_d[k].im_rem    = st_q[k-1].im_rem - REM_W'(dsh);
        st_d[k].im_q[B]   = 1'b1;
      end
      if (SW'(st_q[k-1].sq_rem) >= trial) begin
        st_d[k].sq_rem  = st_q[k-1].sq_rem - MAG_W'(trial);
        st_d[k].root[B] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k <= ITERS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy[0]) st_q[0] <= st_d[0];
    for (int k = 1; k <= ITERS; k++) begin
      if (v_q[k-1] && rdy[k]) st_q[k] <= st_d[k];
    end
  end

endmodule

// File: rtl/complex_fixed_point_alu.sv
// Throughput: one request per cycle while the output is taken; the divide and square root
// advance one bit per stage.
// A stalled output holds its result while empty stages upstream keep filling.
// Reset clears every stage valid bit; the unit is stateless and ready right after reset.
// Stages: products, sums and clamps, overflow check, 16 digit stages, output register.
module complex_fixed_point_alu import cfa_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [CW-1:0] cmd_i,
  input  logic [PW-1:0] a_re_i,
  input  logic [PW-1:0] a_im_i,
  input  logic [PW-1:0] b_re_i,
  input  logic [PW-1:0] b_im_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [PW-1:0] z_re_o,
  output logic [PW-1:0] z_im_o,
  output logic          div_by_zero_o,
  output logic          saturated_o
);

  logic      prep_valid, prep_ready, iter_valid, out_rdy;
  cfa_work_t work;
  cfa_iter_t it;

  logic          out_valid_q;
  logic [PW-1:0] z_re_q, z_im_q, z_re_d, z_im_d;
  logic          dz_q, sat_q, dz_d, sat_d;

  cfa_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .cmd_i   (cmd_i),
    .a_re_i  (a_re_i),
    .a_im_i  (a_im_i),
    .b_re_i  (b_re_i),
    .b_im_i  (b_im_i),
    .valid_o (prep_valid),
    .ready_i (prep_ready),
    .work_o  (work)
  );

  cfa_iter u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .work_i  (work),
    .valid_o (iter_valid),
    .ready_i (out_rdy),
    .iter_o  (it)
  );

  assign out_rdy = !out_valid_q || out_ready_i;

  logic signed [WIDE_W-1:0] q_re, q_im, big;
  cfa_clamp_t c_re, c_im, c_mag;

  always_comb begin
    big   = WIDE_W'(1) <<< (QW + 1);
    q_re  = it.re_ovf ? big : WIDE_W'(it.re_q);
    q_im  = it.im_ovf ? big : WIDE_W'(it.im_q);
    if (it.re_neg) q_re = -q_re;
    if (it.im_neg) q_im = -q_im;
    c_re  = clamp_part(q_re);
    c_im  = clamp_part(q_im);
    c_mag = clamp_part(WIDE_W'(it.root));
    z_re_d = '0;
    z_im_d = '0;
    dz_d   = 1'b0;
    sat_d  = 1'b0;
    case (it.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_CONJ: begin
        z_re_d = it.z_re;
        z_im_d = it.z_im;
        sat_d  = it.sat;
      end
      CMD_DIV: begin
        if (it.dz) begin
          dz_d = 1'b1;
        end else begin
          z_re_d = c_re.val;
          z_im_d = c_im.val;
          sat_d  = c_re.sat | c_im.sat;
        end
      end
      CMD_MAG: begin
        z_re_d = c_mag.val;
        sat_d  = c_mag.sat;
      end
      default: begin
        z_re_d = '0;
        z_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= iter_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (iter_valid && out_rdy) begin
      z_re_q <= z_re_d;
      z_im_q <= z_im_d;
      dz_q   <= dz_d;
      sat_q  <= sat_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign z_re_o        = z_re_q;
  assign z_im_o        = z_im_q;
  assign div_by_zero_o = dz_q;
  assign saturated_o   = sat_q;

endmodule
